>>> src/ccx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ccx_pkg
// Shared constants, register indexes and types of the ChaCha keystream XOR
// block.
// ============================================================================
package ccx_pkg;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_KEY3  = 3'd3;
   localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
   localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
   localparam logic [2:0] REG_ROUNDS     = 3'd6;

   localparam int QUEUE_DEPTH = 2;

   // Classified word handed from the front part to the back part.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic [3:0]  used;       // bytes used, at most eight
      logic [5:0]  pos;        // byte position of the first used byte
      logic [31:0] counter;    // block counter of the first used byte
      logic        new_first;  // first byte starts a fresh block
      logic        straddle;   // used bytes cross into the next block
   } item_type;

   typedef struct packed {
      logic [255:0] key;
      logic [95:0]  nonce;
      logic [3:0]   rounds;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } core_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [127:0] qround(input logic [127:0] q);
      logic [31:0] a, b, c, d;
      begin
         a = q[31:0]; b = q[63:32]; c = q[95:64]; d = q[127:96];
         a = a + b; d = rotl(d ^ a, 16);
         c = c + d; b = rotl(b ^ c, 12);
         a = a + b; d = rotl(d ^ a, 8);
         c = c + d; b = rotl(b ^ c, 7);
         qround = {d, c, b, a};
      end
   endfunction

endpackage
`default_nettype wire

>>> src/chacha_keystream_xor.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chacha_keystream_xor
// ChaCha20 (IETF layout) keystream generator that XORs up to eight bytes
// per word.
// ============================================================================
// Words that need no new 64-byte block flow through the back part one per
// cycle while the output is not stalled. A word that needs a new block
// waits for the shared round unit, one column or diagonal round per cycle,
// and the feed-forward add; a word that crosses a block boundary waits the
// same way for the next block. A two-entry queue lets input words be
// accepted while a block is being made, and the output register holds a
// result under stall.
module chacha_keystream_xor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_in,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_data_out,
   output logic [3:0]       rsp_byte_count_out,
   output logic             rsp_last_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import ccx_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_KEY0:       cfg_in.key[63:0]    = csr_data;
            REG_KEY1:       cfg_in.key[127:64]  = csr_data;
            REG_KEY2:       cfg_in.key[191:128] = csr_data;
            REG_KEY3:       cfg_in.key[255:192] = csr_data;
            REG_NONCE_LOW:  cfg_in.nonce[63:0]  = csr_data;
            REG_NONCE_HIGH: cfg_in.nonce[95:64] = csr_data[31:0];
            REG_ROUNDS:     cfg_in.rounds       = csr_data[3:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key    <= '0;
         cfg_ff.nonce  <= '0;
         cfg_ff.rounds <= 4'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_in    (req_data_in),
      .req_byte_count (req_byte_count),
      .req_last_in    (req_last_in),
      .q_item         (q_item),
      .q_valid        (q_valid),
      .q_pop          (q_pop)
   );

   ccx_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_item             (q_item),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .cfg                (cfg_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_byte_count_out (rsp_byte_count_out),
      .rsp_last_out       (rsp_last_out)
   );

endmodule
`default_nettype wire

>>> src/ccx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ccx_front
// Accepts input words, tracks byte position and block counter, and pushes
// each classified word into a short queue for the back part.
// ============================================================================
module ccx_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [63:0]        req_data_in,
   input  wire logic [3:0]         req_byte_count,
   input  wire logic               req_last_in,
   output ccx_pkg::item_type       q_item,
   output logic                    q_valid,
   input  wire logic               q_pop
);
   import ccx_pkg::*;

   item_type    mem_ff [QUEUE_DEPTH];
   logic [0:0]  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  fill_ff, fill_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] ctr_ff, ctr_in;
   logic        accept;
   logic [3:0]  used;
   logic [6:0]  end_pos;
   item_type    item;

   assign req_stall = (fill_ff == 2'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign used      = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
   assign end_pos   = {1'b0, pos_ff} + {3'b0, used};

   always_comb begin
      item.data      = req_data_in;
      item.count     = req_byte_count;
      item.last      = req_last_in;
      item.used      = used;
      item.pos       = pos_ff;
      item.counter   = ctr_ff;
      item.new_first = (pos_ff == 6'd0) && (used != 4'd0);
      item.straddle  = end_pos > 7'd64;
      pos_in = pos_ff;
      ctr_in = ctr_ff;
      if (accept) begin
         if (req_last_in) begin
            pos_in = 6'd0;
            ctr_in = 32'd0;
         end else begin
            pos_in = end_pos[5:0];
            if (end_pos[6]) ctr_in = ctr_ff + 32'd1;
         end
      end
      fill_in = fill_ff + {1'b0, accept} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         pos_ff    <= '0;
         ctr_ff    <= '0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         ctr_ff  <= ctr_in;
         if (accept) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem_ff[wr_ptr_ff] <= item;
   end

   assign q_item  = mem_ff[rd_ptr_ff];
   assign q_valid = (fill_ff != 2'd0);

endmodule
`default_nettype wire

>>> src/ccx_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ccx_core
// ChaCha block function: one column or diagonal round per cycle, then the
// feed-forward add into a 512-bit keystream register.
// ============================================================================
module ccx_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ccx_pkg::cfg_type  cfg,
   input  wire logic [31:0]       counter,
   output logic                   done,
   output logic [511:0]           keystream
);
   import ccx_pkg::*;

   core_state_type state_ff, state_in;
   logic [511:0] init_ff, w_ff, w_in, round_out, ks_ff;
   logic [511:0] init_new;
   logic [4:0]   step_ff, step_in;
   logic [4:0]   steps;
   logic         load, run, fin;
   logic         done_ff;
   logic [31:0]  x [16];
   logic [31:0]  y [16];
   logic [127:0] q0, q1, q2, q3;

   assign init_new = {cfg.nonce, counter, cfg.key, SIGMA3, SIGMA2, SIGMA1, SIGMA0};
   assign steps    = {cfg.rounds, 1'b0};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = (steps == 5'd0) ? ST_FINISH : ST_ROUND;
         ST_ROUND:  if (step_ff == 5'd1) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load = 1'b0; run = 1'b0; fin = 1'b0;
      case (state_ff)
         ST_IDLE:   load = start;
         ST_ROUND:  run  = 1'b1;
         ST_FINISH: fin  = 1'b1;
         default:   ;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 16; i++) x[i] = w_ff[32*i +: 32];
      if (step_ff[0] == steps[0]) begin
         q0 = qround({x[12], x[8], x[4], x[0]});
         q1 = qround({x[13], x[9], x[5], x[1]});
         q2 = qround({x[14], x[10], x[6], x[2]});
         q3 = qround({x[15], x[11], x[7], x[3]});
         y[0] = q0[31:0]; y[4] = q0[63:32]; y[8]  = q0[95:64]; y[12] = q0[127:96];
         y[1] = q1[31:0]; y[5] = q1[63:32]; y[9]  = q1[95:64]; y[13] = q1[127:96];
         y[2] = q2[31:0]; y[6] = q2[63:32]; y[10] = q2[95:64]; y[14] = q2[127:96];
         y[3] = q3[31:0]; y[7] = q3[63:32]; y[11] = q3[95:64]; y[15] = q3[127:96];
      end else begin
         q0 = qround({x[15], x[10], x[5], x[0]});
         q1 = qround({x[12], x[11], x[6], x[1]});
         q2 = qround({x[13], x[8], x[7], x[2]});
         q3 = qround({x[14], x[9], x[4], x[3]});
         y[0] = q0[31:0]; y[5] = q0[63:32]; y[10] = q0[95:64]; y[15] = q0[127:96];
         y[1] = q1[31:0]; y[6] = q1[63:32]; y[11] = q1[95:64]; y[12] = q1[127:96];
         y[2] = q2[31:0]; y[7] = q2[63:32]; y[8]  = q2[95:64]; y[13] = q2[127:96];
         y[3] = q3[31:0]; y[4] = q3[63:32]; y[9]  = q3[95:64]; y[14] = q3[127:96];
      end
      for (int i = 0; i < 16; i++) round_out[32*i +: 32] = y[i];
   end

   always_comb begin
      w_in    = w_ff;
      step_in = step_ff;
      if (load) begin
         w_in    = init_new;
         step_in = steps;
      end else if (run) begin
         w_in    = round_out;
         step_in = step_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fin;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      step_ff <= step_in;
      if (load) init_ff <= init_new;
      if (fin) begin
         for (int i = 0; i < 16; i++)
            ks_ff[32*i +: 32] <= w_ff[32*i +: 32] + init_ff[32*i +: 32];
      end
   end

   assign done      = done_ff;
   assign keystream = ks_ff;

endmodule
`default_nettype wire

>>> src/ccx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ccx_back
// Takes classified words from the queue, makes keystream blocks as needed,
// XORs the data and holds the result in an output register.
// ============================================================================
module ccx_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ccx_pkg::item_type q_item,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire ccx_pkg::cfg_type  cfg,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [63:0]            rsp_data_out,
   output logic [3:0]             rsp_byte_count_out,
   output logic                   rsp_last_out
);
   import ccx_pkg::*;

   logic         core_start, core_done;
   logic [511:0] ks;
   logic [31:0]  core_ctr;
   logic         busy_ff, busy_in;
   logic         phase_ff, phase_in;    // second block of a straddling word
   logic [63:0]  part_ff, part_in;      // bytes finished before the straddle
   logic         valid_ff, valid_in;
   logic [63:0]  data_ff;
   logic [3:0]   cnt_ff;
   logic         last_ff;
   logic         out_free, ready_now, finish;
   logic [63:0]  xored, merged;
   logic [6:0]   idx;

   ccx_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .cfg       (cfg),
      .counter   (core_ctr),
      .done      (core_done),
      .keystream (ks)
   );

   assign out_free = !valid_ff || !rsp_stall;
   assign core_ctr = phase_in ? q_item.counter + 32'd1 : q_item.counter;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         idx = {1'b0, q_item.pos} + 7'(i);
         xored[8*i +: 8] = q_item.data[8*i +: 8] ^ ks[8*idx[5:0] +: 8];
      end
      merged = '0;
      for (int i = 0; i < 8; i++) begin
         idx = {1'b0, q_item.pos} + 7'(i);
         if (4'(i) < q_item.used) begin
            if (q_item.straddle && !idx[6]) merged[8*i +: 8] = part_ff[8*i +: 8];
            else merged[8*i +: 8] = xored[8*i +: 8];
         end
      end
   end

   always_comb begin
      core_start = 1'b0;
      busy_in    = busy_ff;
      phase_in   = phase_ff;
      part_in    = part_ff;
      finish     = 1'b0;
      ready_now  = 1'b0;
      if (busy_ff) begin
         if (core_done) begin
            busy_in = 1'b0;
            if (q_item.straddle && !phase_ff) begin
               part_in    = xored;
               phase_in   = 1'b1;
               busy_in    = 1'b1;
               core_start = 1'b1;
            end
         end
      end else if (q_valid) begin
         ready_now = 1'b1;
         if (q_item.new_first && !phase_ff) begin
            busy_in    = 1'b1;
            core_start = 1'b1;
            ready_now  = 1'b0;
         end else if (q_item.straddle && !phase_ff) begin
            part_in    = xored;
            phase_in   = 1'b1;
            busy_in    = 1'b1;
            core_start = 1'b1;
            ready_now  = 1'b0;
         end
      end
      if (busy_ff && core_done && !(q_item.straddle && !phase_ff)) ready_now = 1'b1;
      if (ready_now && out_free) begin
         finish   = 1'b1;
         phase_in = 1'b0;
      end
      // A computed block waits in place when the output is full.
      if (ready_now && !out_free && busy_ff) busy_in = 1'b0;
      if (ready_now && !out_free && q_item.new_first) phase_in = 1'b1;
      if (finish) phase_in = 1'b0;
      valid_in = finish || (valid_ff && rsp_stall);
   end

   // Straddling words set phase when their next block starts, so a finished
   // word keyed on phase never rebuilds a block.
   assign q_pop = finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      if (finish) begin
         data_ff <= merged;
         cnt_ff  <= q_item.count;
         last_ff <= q_item.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_data_out       = data_ff;
   assign rsp_byte_count_out = cnt_ff;
   assign rsp_last_out       = last_ff;

endmodule
`default_nettype wire

>>> src/ccx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ccx_checker
// Port-level checks of the ChaCha keystream XOR block.
// ============================================================================
module ccx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_data_out,
   input wire logic [3:0]  rsp_byte_count_out,
   input wire logic        csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("stalled word changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word valid after reset");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count_out == 4'd0 |-> rsp_data_out == 64'd0)
      else $error("empty word carries data");

   a_csr: assert property (@(posedge clock) csr_ready)
      else $error("config port not ready");
endmodule

bind chacha_keystream_xor ccx_checker u_ccx_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_out       (rsp_data_out),
   .rsp_byte_count_out (rsp_byte_count_out),
   .csr_ready          (csr_ready)
);
`default_nettype wire

>>> test/chacha_keystream_xor_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// chacha_keystream_xor_tb
// Self-checking testbench for the ChaCha keystream XOR block. A behavioral
// cipher model predicts every result word; directed and random messages are
// sent under random valid gaps and result stalls across several key, nonce
// and round settings.
// ============================================================================
module chacha_keystream_xor_tb;
   import ccx_pkg::*;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
   } word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_in;
   logic [3:0]  req_byte_count;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_data_out;
   logic [3:0]  rsp_byte_count_out;
   logic        rsp_last_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   logic [63:0] key_word [4];
   logic [63:0] nonce_lo;
   logic [31:0] nonce_hi;
   logic [3:0]  round_pairs;
   logic [31:0] block_num;
   logic [5:0]  byte_pos;
   logic [7:0]  stream_bytes [64];

   word_type    expected_words [$];
   int          mismatches;
   bit          rsp_gaps_on;

   chacha_keystream_xor u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_in(req_data_in),
      .req_byte_count(req_byte_count), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data_out(rsp_data_out),
      .rsp_byte_count_out(rsp_byte_count_out), .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic logic [31:0] rot_left(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void mix(ref logic [31:0] x[16], input int a, int b, int c, int d);
      x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 16);
      x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 12);
      x[a] = x[a] + x[b]; x[d] = rot_left(x[d] ^ x[a], 8);
      x[c] = x[c] + x[d]; x[b] = rot_left(x[b] ^ x[c], 7);
   endfunction

   function automatic void build_stream_block();
      logic [31:0] init [16];
      logic [31:0] work [16];
      logic [31:0] sum;
      init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2 * k] = key_word[k][31:0];
         init[5 + 2 * k] = key_word[k][63:32];
      end
      init[12] = block_num;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      work = init;
      for (int r = 0; r < round_pairs; r++) begin
         mix(work, 0, 4, 8, 12); mix(work, 1, 5, 9, 13);
         mix(work, 2, 6, 10, 14); mix(work, 3, 7, 11, 15);
         mix(work, 0, 5, 10, 15); mix(work, 1, 6, 11, 12);
         mix(work, 2, 7, 8, 13); mix(work, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         sum = work[i] + init[i];
         for (int j = 0; j < 4; j++) stream_bytes[4 * i + j] = sum[8 * j +: 8];
      end
   endfunction

   function automatic word_type encrypt_word(word_type w);
      word_type res;
      int       used;
      used = (w.count > 8) ? 8 : w.count;
      res.data = '0;
      res.count = w.count;
      res.last = w.last;
      for (int i = 0; i < used; i++) begin
         if (byte_pos == 0) build_stream_block();
         res.data[8 * i +: 8] = w.data[8 * i +: 8] ^ stream_bytes[byte_pos];
         byte_pos = byte_pos + 1;
         if (byte_pos == 0) block_num = block_num + 1;
      end
      if (w.last) begin
         block_num = '0;
         byte_pos = '0;
      end
      return res;
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(logic [63:0] data, logic [3:0] count, logic last);
      word_type w;
      int       gap;
      w.data = data; w.count = count; w.last = last;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_in <= data;
      req_byte_count <= count;
      req_last_in <= last;
      expected_words.push_back(encrypt_word(w));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_KEY0: key_word[0] = value;
         REG_KEY1: key_word[1] = value;
         REG_KEY2: key_word[2] = value;
         REG_KEY3: key_word[3] = value;
         REG_NONCE_LOW: nonce_lo = value;
         REG_NONCE_HIGH: nonce_hi = value[31:0];
         REG_ROUNDS: round_pairs = value[3:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                logic [63:0] k3, logic [63:0] nl, logic [31:0] nh,
                                logic [3:0] rounds);
      wait_idle();
      write_reg(REG_KEY0, k0);
      write_reg(REG_KEY1, k1);
      write_reg(REG_KEY2, k2);
      write_reg(REG_KEY3, k3);
      write_reg(REG_NONCE_LOW, nl);
      write_reg(REG_NONCE_HIGH, {32'd0, nh});
      write_reg(REG_ROUNDS, {60'd0, rounds});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed();
      send_word(64'd0, 4'd8, 1'b0);
      send_word('1, 4'd8, 1'b0);
      send_word(64'h0123456789abcdef, 4'd1, 1'b0);
      send_word(rand64(), 4'd0, 1'b0);
      send_word(rand64(), 4'd15, 1'b0);
      send_word(rand64(), 4'd9, 1'b0);
      for (int i = 0; i < 7; i++) send_word(rand64(), 4'd8, 1'b0);
      send_word(rand64(), 4'd5, 1'b0);
      send_word(rand64(), 4'd8, 1'b1);
      send_word(rand64(), 4'd0, 1'b1);
      send_word('1, 4'd3, 1'b1);
      for (int i = 0; i < 9; i++) send_word(rand64(), 4'd7, i == 8);
   endtask

   task automatic test_random_messages(int words);
      int          sent;
      int          length;
      logic [3:0]  count;
      sent = 0;
      while (sent < words) begin
         length = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20)
                                             : $urandom_range(21, 60);
         for (int i = 0; i < length; i++) begin
            case ($urandom_range(0, 9))
               0: count = $urandom_range(0, 15);
               1, 2: count = $urandom_range(1, 7);
               default: count = 4'd8;
            endcase
            send_word(rand64(), count, i == length - 1);
         end
         sent += length;
      end
   endtask

   task automatic test_counter_wrap();
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), 4'd10);
      for (int i = 0; i < 40; i++) send_word(rand64(), 4'd8, i == 39);
   endtask

   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result word: data %h count %0d last %0b",
                        rsp_data_out, rsp_byte_count_out, rsp_last_out);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data_out !== want.data || rsp_byte_count_out !== want.count ||
                rsp_last_out !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                           want.data, want.count, want.last, rsp_data_out,
                           rsp_byte_count_out, rsp_last_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !rsp_gaps_on) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= ($urandom_range(0, 9) < 6);
      else rsp_stall <= ($urandom_range(0, 99) < 20);
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_in = '0;
      req_byte_count = '0;
      req_last_in = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_KEY0;
      csr_data = '0;
      mismatches = 0;
      rsp_gaps_on = 1'b0;
      for (int k = 0; k < 4; k++) key_word[k] = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      round_pairs = 4'd10;
      block_num = '0;
      byte_pos = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rsp_gaps_on = 1'b1;
      load_settings('1, '1, '1, '1, '1, '1, 4'd6);
      test_directed();
      load_settings(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                    64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 4'd10);
      test_random_messages(400);
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), 4'd0);
      test_random_messages(150);
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), 4'd15);
      test_random_messages(150);
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(),
                    $urandom_range(0, 15));
      test_random_messages(400);
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(), 4'd6);
      rsp_gaps_on = 1'b0;
      test_random_messages(200);
      rsp_gaps_on = 1'b1;
      test_counter_wrap();
      test_random_messages(200);
      wait_idle();
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> filelist.f
src/ccx_pkg.sv
src/ccx_front.sv
src/ccx_core.sv
src/ccx_back.sv
src/chacha_keystream_xor.sv
src/ccx_checker.sv
test/chacha_keystream_xor_tb.sv
